// ===== sv/bmh_pkg.sv =====
// shared types, opcodes and status codes for the binary max-heap engine
package bmh_pkg;

  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = KEY_W + TAG_W;
  localparam int COUNT_W = 11;
  localparam int RIDX_W  = 10;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_SORT    = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BADIX = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  function automatic logic key_lt(input logic signed [KEY_W-1:0] a,
                                  input logic signed [KEY_W-1:0] b);
    return a < b;
  endfunction

endpackage

// ===== sv/bmh_ram.sv =====
// generic single-write, single-read ram with registered read data
module bmh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/binary_max_heap_engine_core.sv =====
// binary max-heap engine: insert, extract max, in-place heapsort and indexed read
//
// channel  direction  ports
// in       input      in_valid, in_ready, in_opcode, in_key, in_tag, in_read_index
// out      output     out_valid, out_ready, out_key_out, out_tag_out, out_status, out_count
//
// insert climbs level by level toward the root, extract moves the last entry to the root and
// descends level by level, read does a single ram read; sort repeats a root swap and descent.
// every level costs one or two reads of the heap ram (registered read data) and one write back.
// reset clears the state, the entry count and out_valid only; the ram holds no reset value and is never swept.
// a finished word waits in the output register; the next word is taken once the
// engine is back in idle, even while that result still waits for out_ready.
module binary_max_heap_engine_core #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic signed [bmh_pkg::KEY_W-1:0]    in_key,
  input  logic [bmh_pkg::TAG_W-1:0]           in_tag,
  input  logic [bmh_pkg::RIDX_W-1:0]          in_read_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bmh_pkg::KEY_W-1:0]    out_key_out,
  output logic [bmh_pkg::TAG_W-1:0]           out_tag_out,
  output logic [1:0]                          out_status,
  output logic [bmh_pkg::COUNT_W-1:0]         out_count
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = CW + 1;
  localparam int RW = (CW > bmh_pkg::RIDX_W) ? CW : bmh_pkg::RIDX_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EX_ROOT = 4'd1;
  localparam logic [3:0] S_EX_LAST = 4'd2;
  localparam logic [3:0] S_SO_RD0  = 4'd3;
  localparam logic [3:0] S_SO_ROOT = 4'd4;
  localparam logic [3:0] S_SO_LAST = 4'd5;
  localparam logic [3:0] S_UP_CHK  = 4'd6;
  localparam logic [3:0] S_UP_CMP  = 4'd7;
  localparam logic [3:0] S_DN_L    = 4'd8;
  localparam logic [3:0] S_DN_R    = 4'd9;
  localparam logic [3:0] S_DN_C2   = 4'd10;
  localparam logic [3:0] S_RD      = 4'd11;
  localparam logic [3:0] S_POST    = 4'd12;

  logic [3:0]                       state_r, state_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [CW-1:0]                    len_r, len_nxt;
  logic [AW-1:0]                    pos_r, pos_nxt;
  logic [1:0]                       op_r, op_nxt;
  bmh_pkg::entry_t                  mov_r, mov_nxt;
  bmh_pkg::entry_t                  kid_r, kid_nxt;
  logic                             kid_big_r, kid_big_nxt;
  logic signed [bmh_pkg::KEY_W-1:0] res_key_r, res_key_nxt;
  logic [bmh_pkg::TAG_W-1:0]        res_tag_r, res_tag_nxt;
  logic [1:0]                       res_status_r, res_status_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [bmh_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic [bmh_pkg::TAG_W-1:0]        out_tag_r, out_tag_nxt;
  logic [1:0]                       out_status_r, out_status_nxt;
  logic [bmh_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  bmh_pkg::entry_t                  ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [bmh_pkg::ENTRY_W-1:0]      ram_rdata;
  bmh_pkg::entry_t                  rd;

  logic [IW-1:0]                    lchild;
  logic [IW-1:0]                    rchild;
  logic [IW-1:0]                    len_ext;
  logic [AW-1:0]                    parent;
  logic [3:0]                       dn_done;
  logic                             accept;
  logic                             out_free;
  logic                             big_l;
  logic signed [bmh_pkg::KEY_W-1:0] cand_key;

  bmh_ram #(
    .WIDTH (bmh_pkg::ENTRY_W),
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = bmh_pkg::entry_t'(ram_rdata);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign lchild   = (IW'(pos_r) << 1) + IW'(1);
  assign rchild   = lchild + IW'(1);
  assign len_ext  = IW'(len_r);
  assign parent   = (pos_r - AW'(1)) >> 1;
  assign dn_done  = (op_r == bmh_pkg::OP_SORT && len_r > CW'(1)) ? S_SO_RD0 : S_POST;
  assign big_l    = bmh_pkg::key_lt(mov_r.key, rd.key);
  assign cand_key = kid_big_r ? kid_r.key : mov_r.key;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    op_nxt         = op_r;
    mov_nxt        = mov_r;
    kid_nxt        = kid_r;
    kid_big_nxt    = kid_big_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = mov_r;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_opcode;
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = bmh_pkg::ST_OK;
          case (in_opcode)
            bmh_pkg::OP_INSERT: begin
              if (count_r == CW'(HEAP_DEPTH)) begin
                res_status_nxt = bmh_pkg::ST_FULL;
                state_nxt      = S_POST;
              end else begin
                mov_nxt   = '{key: in_key, tag: in_tag};
                pos_nxt   = AW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP_CHK;
              end
            end
            bmh_pkg::OP_EXTRACT: begin
              if (count_r == '0) begin
                res_status_nxt = bmh_pkg::ST_EMPTY;
                state_nxt      = S_POST;
              end else begin
                ram_raddr = '0;
                state_nxt = S_EX_ROOT;
              end
            end
            bmh_pkg::OP_SORT: begin
              if (count_r > CW'(1)) begin
                len_nxt   = count_r;
                state_nxt = S_SO_RD0;
              end else begin
                state_nxt = S_POST;
              end
            end
            bmh_pkg::OP_READ: begin
              if (RW'(in_read_index) >= RW'(count_r)) begin
                res_status_nxt = bmh_pkg::ST_BADIX;
                state_nxt      = S_POST;
              end else begin
                ram_raddr = AW'(in_read_index);
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EX_ROOT: begin
        res_key_nxt = rd.key;
        res_tag_nxt = rd.tag;
        ram_raddr   = AW'(count_r - CW'(1));
        state_nxt   = S_EX_LAST;
      end
      S_EX_LAST: begin
        mov_nxt   = rd;
        count_nxt = count_r - CW'(1);
        len_nxt   = count_r - CW'(1);
        pos_nxt   = '0;
        state_nxt = S_DN_L;
      end
      S_SO_RD0: begin
        ram_raddr = '0;
        state_nxt = S_SO_ROOT;
      end
      S_SO_ROOT: begin
        kid_nxt   = rd;
        ram_raddr = AW'(len_r - CW'(1));
        state_nxt = S_SO_LAST;
      end
      S_SO_LAST: begin
        mov_nxt   = rd;
        ram_we    = 1'b1;
        ram_waddr = AW'(len_r - CW'(1));
        ram_wdata = kid_r;
        len_nxt   = len_r - CW'(1);
        pos_nxt   = '0;
        state_nxt = S_DN_L;
      end
      S_UP_CHK: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = mov_r;
          state_nxt = S_POST;
        end else begin
          ram_raddr = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (bmh_pkg::key_lt(rd.key, mov_r.key)) begin
          ram_wdata = rd;
          pos_nxt   = parent;
          state_nxt = S_UP_CHK;
        end else begin
          ram_wdata = mov_r;
          state_nxt = S_POST;
        end
      end
      S_DN_L: begin
        if (lchild >= len_ext) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = mov_r;
          state_nxt = dn_done;
        end else begin
          ram_raddr = lchild[AW-1:0];
          state_nxt = S_DN_R;
        end
      end
      S_DN_R: begin
        kid_nxt     = rd;
        kid_big_nxt = big_l;
        if (rchild < len_ext) begin
          ram_raddr = rchild[AW-1:0];
          state_nxt = S_DN_C2;
        end else if (big_l) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = rd;
          pos_nxt   = lchild[AW-1:0];
          state_nxt = S_DN_L;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = mov_r;
          state_nxt = dn_done;
        end
      end
      S_DN_C2: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (bmh_pkg::key_lt(cand_key, rd.key)) begin
          ram_wdata = rd;
          pos_nxt   = rchild[AW-1:0];
          state_nxt = S_DN_L;
        end else if (kid_big_r) begin
          ram_wdata = kid_r;
          pos_nxt   = lchild[AW-1:0];
          state_nxt = S_DN_L;
        end else begin
          ram_wdata = mov_r;
          state_nxt = dn_done;
        end
      end
      S_RD: begin
        res_key_nxt = rd.key;
        res_tag_nxt = rd.tag;
        state_nxt   = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = res_key_r;
          out_tag_nxt    = res_tag_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = bmh_pkg::COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    pos_r        <= pos_nxt;
    op_r         <= op_nxt;
    mov_r        <= mov_nxt;
    kid_r        <= kid_nxt;
    kid_big_r    <= kid_big_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_key_out = out_key_r;
  assign out_tag_out = out_tag_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;

endmodule

// ===== dv/binary_max_heap_engine_core_tb.sv =====
// testbench for the binary max-heap engine: directed rows and random traffic with stalls
`timescale 1ns / 1ps

module binary_max_heap_engine_core_tb;

  localparam int HEAP_DEPTH     = 1024;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_WORDS   = 430;

  typedef struct {
    logic signed [bmh_pkg::KEY_W-1:0] key;
    logic [bmh_pkg::TAG_W-1:0]        tag;
    logic [1:0]                       status;
    logic [bmh_pkg::COUNT_W-1:0]      count;
  } heap_result_t;

  typedef struct {
    logic [1:0]                       op;
    logic signed [bmh_pkg::KEY_W-1:0] key;
    logic [bmh_pkg::TAG_W-1:0]        tag;
    logic [bmh_pkg::RIDX_W-1:0]       ridx;
    bit                               typed;
    heap_result_t                     want;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [1:0]                         in_opcode = bmh_pkg::OP_INSERT;
  logic signed [bmh_pkg::KEY_W-1:0]   in_key = '0;
  logic [bmh_pkg::TAG_W-1:0]          in_tag = '0;
  logic [bmh_pkg::RIDX_W-1:0]         in_read_index = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [bmh_pkg::KEY_W-1:0]   out_key_out;
  logic [bmh_pkg::TAG_W-1:0]          out_tag_out;
  logic [1:0]                         out_status;
  logic [bmh_pkg::COUNT_W-1:0]        out_count;

  bmh_pkg::entry_t mirror_heap [HEAP_DEPTH];
  int              mirror_count = 0;
  heap_result_t    awaited_words [$];
  stim_row_t       stim_rows [$];

  int mismatches  = 0;
  int words_in    = 0;
  int words_out   = 0;
  int sorts_done  = 0;
  int peak_fill   = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;

  binary_max_heap_engine_core #(.HEAP_DEPTH(HEAP_DEPTH)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_key        (in_key),
    .in_tag        (in_tag),
    .in_read_index (in_read_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_out   (out_key_out),
    .out_tag_out   (out_tag_out),
    .out_status    (out_status),
    .out_count     (out_count)
  );

  always #1 clk = ~clk;

  function automatic void swap_slots(int a, int b);
    bmh_pkg::entry_t t;
    t = mirror_heap[a];
    mirror_heap[a] = mirror_heap[b];
    mirror_heap[b] = t;
  endfunction

  function automatic bit key_below(int a, int b);
    return $signed(mirror_heap[a].key) < $signed(mirror_heap[b].key);
  endfunction

  function automatic void settle_down(int pos, int len);
    int l;
    int r;
    int big;
    bit done;
    done = 1'b0;
    while (!done) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      big = pos;
      if (l < len && key_below(pos, l)) big = l;
      if (r < len && key_below(big, r)) big = r;
      if (big == pos) begin
        done = 1'b1;
      end else begin
        swap_slots(pos, big);
        pos = big;
      end
    end
  endfunction

  function automatic void settle_up(int pos);
    int up;
    bit done;
    done = 1'b0;
    while (!done && pos > 0) begin
      up = (pos - 1) / 2;
      if (!key_below(up, pos)) begin
        done = 1'b1;
      end else begin
        swap_slots(pos, up);
        pos = up;
      end
    end
  endfunction

  function automatic heap_result_t heap_apply(logic [1:0] op,
                                              logic signed [bmh_pkg::KEY_W-1:0] key,
                                              logic [bmh_pkg::TAG_W-1:0] tag,
                                              logic [bmh_pkg::RIDX_W-1:0] ridx);
    heap_result_t r;
    r.key = '0;
    r.tag = '0;
    r.status = bmh_pkg::ST_OK;
    case (op)
      bmh_pkg::OP_INSERT: begin
        if (mirror_count >= HEAP_DEPTH) begin
          r.status = bmh_pkg::ST_FULL;
        end else begin
          mirror_heap[mirror_count].key = key;
          mirror_heap[mirror_count].tag = tag;
          mirror_count++;
          settle_up(mirror_count - 1);
        end
      end
      bmh_pkg::OP_EXTRACT: begin
        if (mirror_count == 0) begin
          r.status = bmh_pkg::ST_EMPTY;
        end else begin
          r.key = mirror_heap[0].key;
          r.tag = mirror_heap[0].tag;
          mirror_heap[0] = mirror_heap[mirror_count - 1];
          mirror_count--;
          settle_down(0, mirror_count);
        end
      end
      bmh_pkg::OP_SORT: begin
        for (int i = mirror_count; i > 1; i--) begin
          swap_slots(0, i - 1);
          settle_down(0, i - 1);
        end
      end
      bmh_pkg::OP_READ: begin
        if (int'(ridx) >= mirror_count) begin
          r.status = bmh_pkg::ST_BADIX;
        end else begin
          r.key = mirror_heap[ridx].key;
          r.tag = mirror_heap[ridx].tag;
        end
      end
      default: begin
      end
    endcase
    r.count = bmh_pkg::COUNT_W'(mirror_count);
    return r;
  endfunction

  function automatic logic signed [bmh_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [bmh_pkg::RIDX_W-1:0] pick_index();
    if (mirror_count > 0 && $urandom_range(0, 9) < 7) begin
      return bmh_pkg::RIDX_W'($urandom_range(0, mirror_count - 1));
    end
    return bmh_pkg::RIDX_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [1:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return bmh_pkg::OP_INSERT;
    if (roll < 70) return bmh_pkg::OP_EXTRACT;
    if (roll < 92) return bmh_pkg::OP_READ;
    return bmh_pkg::OP_SORT;
  endfunction

  task automatic add_row(logic [1:0] op, logic signed [bmh_pkg::KEY_W-1:0] key,
                         logic [bmh_pkg::TAG_W-1:0] tag, logic [bmh_pkg::RIDX_W-1:0] ridx,
                         bit typed, logic signed [bmh_pkg::KEY_W-1:0] ek,
                         logic [bmh_pkg::TAG_W-1:0] et, logic [1:0] es,
                         logic [bmh_pkg::COUNT_W-1:0] ec);
    stim_row_t row;
    row.op = op;
    row.key = key;
    row.tag = tag;
    row.ridx = ridx;
    row.typed = typed;
    row.want.key = ek;
    row.want.tag = et;
    row.want.status = es;
    row.want.count = ec;
    stim_rows.push_back(row);
  endtask

  task automatic send_word(logic [1:0] op, logic signed [bmh_pkg::KEY_W-1:0] key,
                           logic [bmh_pkg::TAG_W-1:0] tag, logic [bmh_pkg::RIDX_W-1:0] ridx,
                           bit typed, heap_result_t typed_want);
    heap_result_t predicted;
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_key        <= key;
    in_tag        <= tag;
    in_read_index <= ridx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = heap_apply(op, key, tag, ridx);
    if (typed) awaited_words.push_back(typed_want);
    else awaited_words.push_back(predicted);
    words_in++;
    status_seen[predicted.status]++;
    if (op == bmh_pkg::OP_SORT) sorts_done++;
    if (mirror_count > peak_fill) peak_fill = mirror_count;
  endtask

  task automatic send_random(logic [1:0] op);
    heap_result_t unused;
    unused.key = '0;
    unused.tag = '0;
    unused.status = bmh_pkg::ST_OK;
    unused.count = '0;
    send_word(op, pick_key(), bmh_pkg::TAG_W'($urandom_range(0, 65535)), pick_index(),
              1'b0, unused);
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: bad %s, got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_word();
    heap_result_t want;
    if (awaited_words.size() == 0) begin
      flag_mismatch("word with nothing pending", {32'h0, out_key_out}, '0);
      return;
    end
    want = awaited_words.pop_front();
    words_out++;
    if (out_key_out !== want.key) begin
      flag_mismatch("key_out", {32'h0, out_key_out}, {32'h0, want.key});
    end
    if (out_tag_out !== want.tag) begin
      flag_mismatch("tag_out", 64'(out_tag_out), 64'(want.tag));
    end
    if (out_status !== want.status) begin
      flag_mismatch("status", 64'(out_status), 64'(want.status));
    end
    if (out_count !== want.count) begin
      flag_mismatch("count", 64'(out_count), 64'(want.count));
    end
  endtask

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_word();
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(0, 99) >= 15;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("binary_max_heap_engine_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    heap_result_t unused;
    stim_row_t row;
    unused.key = '0;
    unused.tag = '0;
    unused.status = bmh_pkg::ST_OK;
    unused.count = '0;

    add_row(bmh_pkg::OP_EXTRACT, 0, 0, 0, 1, 0, 0, bmh_pkg::ST_EMPTY, 0);
    add_row(bmh_pkg::OP_READ, 0, 0, 0, 1, 0, 0, bmh_pkg::ST_BADIX, 0);
    add_row(bmh_pkg::OP_READ, 0, 0, 1023, 1, 0, 0, bmh_pkg::ST_BADIX, 0);
    add_row(bmh_pkg::OP_SORT, 0, 0, 0, 1, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 0, 1, 0, 0, bmh_pkg::ST_OK, 1);
    add_row(bmh_pkg::OP_READ, 0, 0, 0, 1, 32'sh7FFF_FFFF, 16'hFFFF, bmh_pkg::ST_OK, 1);
    add_row(bmh_pkg::OP_READ, 0, 0, 1, 1, 0, 0, bmh_pkg::ST_BADIX, 1);
    add_row(bmh_pkg::OP_SORT, 0, 0, 0, 1, 0, 0, bmh_pkg::ST_OK, 1);
    add_row(bmh_pkg::OP_INSERT, 32'sh8000_0000, 16'h0000, 0, 1, 0, 0, bmh_pkg::ST_OK, 2);
    add_row(bmh_pkg::OP_INSERT, 0, 16'h5A5A, 0, 1, 0, 0, bmh_pkg::ST_OK, 3);
    add_row(bmh_pkg::OP_INSERT, -1, 16'hA5A5, 0, 1, 0, 0, bmh_pkg::ST_OK, 4);
    add_row(bmh_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'h0001, 0, 1, 0, 0, bmh_pkg::ST_OK, 5);
    add_row(bmh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_READ, 0, 0, 4, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_EXTRACT, 0, 0, 0, 1, 32'sh7FFF_FFFF, 16'hFFFF, bmh_pkg::ST_OK, 4);
    add_row(bmh_pkg::OP_INSERT, 5, 16'h0F0F, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_INSERT, 5, 16'hF0F0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_EXTRACT, 0, 0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_EXTRACT, 0, 0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_SORT, 0, 0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_READ, 0, 0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_READ, 0, 0, 3, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_INSERT, 3, 16'h1234, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_EXTRACT, 0, 0, 0, 0, 0, 0, bmh_pkg::ST_OK, 0);
    add_row(bmh_pkg::OP_READ, 0, 0, 1023, 0, 0, 0, bmh_pkg::ST_OK, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_word(row.op, row.key, row.tag, row.ridx, row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 100) hold_req = 1'b1;
      calm = (n >= 250 && n < 350);
      send_random(pick_op());
    end
    calm = 1'b0;

    // reads of index 1023 and 0 around a sort, then an insert and a mix of reads and extracts
    send_word(bmh_pkg::OP_READ, 0, 0, 1023, 1'b0, unused);
    send_word(bmh_pkg::OP_READ, 0, 0, 0, 1'b0, unused);
    send_random(bmh_pkg::OP_SORT);
    send_word(bmh_pkg::OP_READ, 0, 0, 0, 1'b0, unused);
    send_word(bmh_pkg::OP_READ, 0, 0, 1023, 1'b0, unused);
    send_random(bmh_pkg::OP_INSERT);
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 2) == 0) send_random(bmh_pkg::OP_READ);
      else send_random(bmh_pkg::OP_EXTRACT);
    end
    in_valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d words in, %0d results checked, %0d sorts, peak fill %0d of %0d",
             words_in, words_out, sorts_done, peak_fill, HEAP_DEPTH);
    $display("statuses: ok %0d, full %0d, empty %0d, bad index %0d",
             status_seen[bmh_pkg::ST_OK], status_seen[bmh_pkg::ST_FULL],
             status_seen[bmh_pkg::ST_EMPTY], status_seen[bmh_pkg::ST_BADIX]);
    if (mismatches == 0) begin
      $display("binary_max_heap_engine_core: match");
    end else begin
      $display("binary_max_heap_engine_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== binary_max_heap_engine_core.f =====
sv/bmh_pkg.sv
sv/bmh_ram.sv
sv/binary_max_heap_engine_core.sv
dv/binary_max_heap_engine_core_tb.sv
